// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the frustum cull RTL.
// Every macro expects clk and rst in scope; checks are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the frustum cull test pipeline.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int NumPlanes   = 6;
  localparam int PlaneWidth  = 64;
  localparam int CfgIdxWidth = 3;
  localparam int CoordWidth  = 16;
  localparam int OpWidth     = CoordWidth + 1;
  localparam int ProdWidth   = OpWidth + CoordWidth;
  localparam int DistWidth   = ProdWidth + 3;
  localparam int OffsetShift = 14;
  localparam int RadiusWidth = 15;

  typedef enum logic [1:0] {
    CMD_BOX    = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // One test as it moves down the row of plane cells.
  typedef struct packed {
    logic                       valid;
    cmd_t                       cmd;
    logic signed [OpWidth-1:0]  lo_x;
    logic signed [OpWidth-1:0]  lo_y;
    logic signed [OpWidth-1:0]  lo_z;
    logic signed [OpWidth-1:0]  hi_x;
    logic signed [OpWidth-1:0]  hi_y;
    logic signed [OpWidth-1:0]  hi_z;
    logic [RadiusWidth-1:0]     radius;
    logic                       done;
    logic                       vis;
  } token_t;

endpackage

// ----- sv/frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test
// View frustum test of boxes, points and spheres against six planes.
// ----------------------------------------------------------------------------
// Use: load the six planes (left, right, top, bottom, far, near) through
// wr_en / wr_index / wr_data while no test is in flight; a, b, c in bits
// 47:0 (Q1.14) and d in bits 63:48 (Q8.8). An index above 5 is dropped.
// A test is transferred at a rising edge with start high and busy low;
// busy is high only during reset, so a new test may start every cycle.
// The result appears on visible for one cycle with done high, after the
// input register, which loads at the transfer edge, two stages in each of
// the six plane cells and one output register. Throughput is one test per
// cycle outside reset; the row of plane cells is fully pipelined, each cell
// holding its own plane. Results leave in transfer order and the receiver
// cannot stall them.
// Reset clears all planes to zero and drops every test in flight.
// ----------------------------------------------------------------------------
module frustum_cull_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            cmd,
  input  logic signed [fct_pkg::CoordWidth-1:0] min_x,
  input  logic signed [fct_pkg::CoordWidth-1:0] min_y,
  input  logic signed [fct_pkg::CoordWidth-1:0] min_z,
  input  logic signed [fct_pkg::CoordWidth-1:0] max_x,
  input  logic signed [fct_pkg::CoordWidth-1:0] max_y,
  input  logic signed [fct_pkg::CoordWidth-1:0] max_z,
  input  logic signed [fct_pkg::CoordWidth-1:0] shift_x,
  input  logic signed [fct_pkg::CoordWidth-1:0] shift_y,
  input  logic signed [fct_pkg::CoordWidth-1:0] shift_z,
  input  logic [fct_pkg::RadiusWidth-1:0]       radius,
  output logic                                  done,
  output logic                                  visible,
  input  logic                                  wr_en,
  input  logic [fct_pkg::CfgIdxWidth-1:0]       wr_index,
  input  logic [fct_pkg::PlaneWidth-1:0]        wr_data
);

  fct_pkg::token_t chain [fct_pkg::NumPlanes+1];
  logic            take;

  assign busy = rst;
  assign take = start && !busy;

  fct_entry u_entry (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .cmd     (cmd),
    .min_x   (min_x),
    .min_y   (min_y),
    .min_z   (min_z),
    .max_x   (max_x),
    .max_y   (max_y),
    .max_z   (max_z),
    .shift_x (shift_x),
    .shift_y (shift_y),
    .shift_z (shift_z),
    .radius  (radius),
    .tok     (chain[0])
  );

  for (genvar i = 0; i < fct_pkg::NumPlanes; i++) begin : g_cell
    fct_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .plane_we   (wr_en && wr_index == fct_pkg::CfgIdxWidth'(i)),
      .plane_data (wr_data),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  // No deciding plane means visible.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[fct_pkg::NumPlanes].valid;
    end
    visible <= chain[fct_pkg::NumPlanes].done ? chain[fct_pkg::NumPlanes].vis : 1'b1;
  end

endmodule

// ----- sv/fct_entry.sv -----
// ----------------------------------------------------------------------------
// fct_entry
// Input register: forms the shifted box corners and opens the token.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fct_entry (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic [1:0]                             cmd,
  input  logic signed [fct_pkg::CoordWidth-1:0]  min_x,
  input  logic signed [fct_pkg::CoordWidth-1:0]  min_y,
  input  logic signed [fct_pkg::CoordWidth-1:0]  min_z,
  input  logic signed [fct_pkg::CoordWidth-1:0]  max_x,
  input  logic signed [fct_pkg::CoordWidth-1:0]  max_y,
  input  logic signed [fct_pkg::CoordWidth-1:0]  max_z,
  input  logic signed [fct_pkg::CoordWidth-1:0]  shift_x,
  input  logic signed [fct_pkg::CoordWidth-1:0]  shift_y,
  input  logic signed [fct_pkg::CoordWidth-1:0]  shift_z,
  input  logic [fct_pkg::RadiusWidth-1:0]        radius,
  output fct_pkg::token_t                        tok
);

  fct_pkg::token_t tok_next;
  fct_pkg::cmd_t   cmd_sel;

  always_comb begin
    cmd_sel         = fct_pkg::cmd_t'(cmd);
    tok_next        = tok;
    tok_next.valid  = take;
    tok_next.cmd    = cmd_sel;
    tok_next.radius = radius;
    tok_next.done   = (cmd_sel == fct_pkg::CMD_NONE);
    tok_next.vis    = (cmd_sel == fct_pkg::CMD_NONE);
    if (cmd_sel == fct_pkg::CMD_BOX) begin
      tok_next.lo_x = fct_pkg::OpWidth'(min_x) + fct_pkg::OpWidth'(shift_x);
      tok_next.lo_y = fct_pkg::OpWidth'(min_y) + fct_pkg::OpWidth'(shift_y);
      tok_next.lo_z = fct_pkg::OpWidth'(min_z) + fct_pkg::OpWidth'(shift_z);
      tok_next.hi_x = fct_pkg::OpWidth'(max_x) + fct_pkg::OpWidth'(shift_x);
      tok_next.hi_y = fct_pkg::OpWidth'(max_y) + fct_pkg::OpWidth'(shift_y);
      tok_next.hi_z = fct_pkg::OpWidth'(max_z) + fct_pkg::OpWidth'(shift_z);
    end else begin
      // point and sphere use the center unshifted
      tok_next.lo_x = fct_pkg::OpWidth'(min_x);
      tok_next.lo_y = fct_pkg::OpWidth'(min_y);
      tok_next.lo_z = fct_pkg::OpWidth'(min_z);
      tok_next.hi_x = fct_pkg::OpWidth'(min_x);
      tok_next.hi_y = fct_pkg::OpWidth'(min_y);
      tok_next.hi_z = fct_pkg::OpWidth'(min_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  `ASSERT_IMPL(a_none_visible, tok.valid && tok.cmd == fct_pkg::CMD_NONE, tok.done && tok.vis, "unused command not marked visible")

endmodule

// ----- sv/fct_cell.sv -----
// ----------------------------------------------------------------------------
// fct_cell
// One plane cell: holds a plane, multiplies in the first stage, sums and
// decides in the second, then hands the token to the next cell.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fct_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                plane_we,
  input  logic [fct_pkg::PlaneWidth-1:0]      plane_data,
  input  fct_pkg::token_t                     tok_in,
  output fct_pkg::token_t                     tok_out
);

  localparam int OpW   = fct_pkg::OpWidth;
  localparam int ProdW = fct_pkg::ProdWidth;
  localparam int DistW = fct_pkg::DistWidth;

  logic [fct_pkg::PlaneWidth-1:0] plane;

  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;
  logic signed [15:0] coef_d;

  fct_pkg::token_t       mid;
  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  logic signed [ProdW-1:0] prod_z;
  logic signed [ProdW-1:0] prod_x_next;
  logic signed [ProdW-1:0] prod_y_next;
  logic signed [ProdW-1:0] prod_z_next;

  logic signed [DistW-1:0] plane_sum;
  logic signed [DistW-1:0] rs;
  logic                    is_box;
  fct_pkg::token_t         tok_next;

  // For a box, pick the corner coordinate that maximizes coef * v over {lo, hi}; else lo.
  function automatic logic signed [OpW-1:0] pick_op(
    input logic              box,
    input logic signed [15:0]    coef,
    input logic signed [OpW-1:0] lo,
    input logic signed [OpW-1:0] hi
  );
    logic hi_big;
    hi_big = (hi > lo);
    if (!box) begin
      return lo;
    end else if (coef >= 0) begin
      return hi_big ? hi : lo;
    end else begin
      return hi_big ? lo : hi;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (plane_we) begin
      plane <= plane_data;
    end
  end

  assign coef_a = plane[15:0];
  assign coef_b = plane[31:16];
  assign coef_c = plane[47:32];
  assign coef_d = plane[63:48];

  assign is_box = (tok_in.cmd == fct_pkg::CMD_BOX);

  always_comb begin
    prod_x_next = ProdW'(coef_a) * ProdW'(pick_op(is_box, coef_a, tok_in.lo_x, tok_in.hi_x));
    prod_y_next = ProdW'(coef_b) * ProdW'(pick_op(is_box, coef_b, tok_in.lo_y, tok_in.hi_y));
    prod_z_next = ProdW'(coef_c) * ProdW'(pick_op(is_box, coef_c, tok_in.lo_z, tok_in.hi_z));
  end

  always_ff @(posedge clk) begin
    prod_x <= prod_x_next;
    prod_y <= prod_y_next;
    prod_z <= prod_z_next;
    if (rst) begin
      mid <= '0;
    end else begin
      mid <= tok_in;
    end
  end

  always_comb begin
    plane_sum = DistW'(prod_x) + DistW'(prod_y) + DistW'(prod_z)
              + (DistW'(coef_d) <<< fct_pkg::OffsetShift);
    rs   = DistW'($signed({1'b0, mid.radius, {fct_pkg::OffsetShift{1'b0}}}));
    tok_next = mid;
    if (!mid.done) begin
      unique case (mid.cmd)
        fct_pkg::CMD_BOX, fct_pkg::CMD_POINT: begin
          if (plane_sum <= 0) begin
            tok_next.done = 1'b1;
            tok_next.vis  = 1'b0;
          end
        end
        fct_pkg::CMD_SPHERE: begin
          // first plane to decide wins
          if (plane_sum < -rs) begin
            tok_next.done = 1'b1;
            tok_next.vis  = 1'b0;
          end else if (plane_sum < rs && plane_sum > -rs) begin
            tok_next.done = 1'b1;
            tok_next.vis  = 1'b1;
          end
        end
        default: begin
          tok_next.done = 1'b1;
          tok_next.vis  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  `ASSERT_NEXT(a_cell_advance, mid.valid, tok_out.valid, "token lost inside cell")
  `ASSERT_IMPL(a_cell_keep, tok_out.valid && $past(tok_in.done, 2), tok_out.done && tok_out.vis == $past(tok_in.vis, 2), "earlier decision overwritten")

endmodule

// ----- dv/frustum_cull_test_test.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test_test
// Self-checking bench for the six-plane box, point and sphere cull test.
// Plane sets are loaded through the write port while no test is in flight.
// Tests stream in with random gaps, back to back for some plane sets. Each visible flag is compared with a
// local model of the fixed-point plane arithmetic.
// ----------------------------------------------------------------------------
module frustum_cull_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPlanes   = fct_pkg::NumPlanes;
  localparam int PlaneWidth  = fct_pkg::PlaneWidth;
  localparam int CfgIdxWidth = fct_pkg::CfgIdxWidth;
  localparam int CoordWidth  = fct_pkg::CoordWidth;
  localparam int RadiusWidth = fct_pkg::RadiusWidth;
  localparam int OffsetShift = fct_pkg::OffsetShift;

  localparam int CoordMax    = 32767;
  localparam int CoordMin    = -32768;
  localparam int RadiusMax   = 32767;
  localparam int UnitNormal  = 16384;
  localparam int CubeHalf    = 4096;
  localparam int NearSpan    = 20480;
  localparam int NumCorners  = 8;
  localparam int TestsPerSet = 104;
  localparam int NumSets     = 10;
  localparam int DrainCycles = 20;
  localparam int StallLimit  = 1000;

  typedef struct packed {
    fct_pkg::cmd_t                cmd;
    logic signed [CoordWidth-1:0] min_x, min_y, min_z;
    logic signed [CoordWidth-1:0] max_x, max_y, max_z;
    logic signed [CoordWidth-1:0] shift_x, shift_y, shift_z;
    logic [RadiusWidth-1:0]       radius;
  } cull_test_t;

  typedef struct {
    cull_test_t t;
    bit         vis;
  } verdict_t;

  typedef enum {
    PLANES_CUBE, PLANES_BOX, PLANES_RANDOM, PLANES_MAXPOS, PLANES_MAXNEG, PLANES_MIXED
  } plane_set_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   start    = 1'b0;
  logic                   wr_en    = 1'b0;
  logic [CfgIdxWidth-1:0] wr_index = '0;
  logic [PlaneWidth-1:0]  wr_data  = '0;
  cull_test_t             drv_test = '0;
  logic                   busy, done, visible;

  cull_test_t            pending_tests[$];
  verdict_t              expected_verdicts[$];
  logic [PlaneWidth-1:0] plane_shadow [NumPlanes] = '{default: '0};
  int                    cmd_count [4] = '{default: 0};
  plane_set_t            set_order [NumSets] = '{
    PLANES_BOX, PLANES_RANDOM, PLANES_BOX, PLANES_MAXPOS, PLANES_BOX,
    PLANES_MAXNEG, PLANES_BOX, PLANES_MIXED, PLANES_BOX, PLANES_RANDOM
  };

  logic xfer        = 1'b0;
  int   gap_left    = 0;
  int   gap_limit   = 7;
  int   n_queued    = 0;
  int   n_results   = 0;
  int   n_errors    = 0;
  int   n_culled    = 0;
  int   n_loads     = 0;
  int   idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frustum_cull_test dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (drv_test.cmd),
    .min_x    (drv_test.min_x),
    .min_y    (drv_test.min_y),
    .min_z    (drv_test.min_z),
    .max_x    (drv_test.max_x),
    .max_y    (drv_test.max_y),
    .max_z    (drv_test.max_z),
    .shift_x  (drv_test.shift_x),
    .shift_y  (drv_test.shift_y),
    .shift_z  (drv_test.shift_z),
    .radius   (drv_test.radius),
    .done     (done),
    .visible  (visible),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Signed distance with 22 fraction bits: a*x + b*y + c*z + d*2^14.
  function automatic longint plane_distance(logic [PlaneWidth-1:0] pl,
                                            longint x, longint y, longint z);
    longint a, b, c, d;
    a = longint'($signed(pl[15:0]));
    b = longint'($signed(pl[31:16]));
    c = longint'($signed(pl[47:32]));
    d = longint'($signed(pl[63:48]));
    return a * x + b * y + c * z + (d <<< OffsetShift);
  endfunction

  function automatic bit cull_verdict(cull_test_t t);
    longint lo [3];
    longint hi [3];
    longint plane_sum, reach;
    int     behind;
    case (t.cmd)
      fct_pkg::CMD_BOX: begin
        lo[0] = longint'(t.min_x) + longint'(t.shift_x);
        lo[1] = longint'(t.min_y) + longint'(t.shift_y);
        lo[2] = longint'(t.min_z) + longint'(t.shift_z);
        hi[0] = longint'(t.max_x) + longint'(t.shift_x);
        hi[1] = longint'(t.max_y) + longint'(t.shift_y);
        hi[2] = longint'(t.max_z) + longint'(t.shift_z);
        for (int p = 0; p < NumPlanes; p++) begin
          behind = 0;
          for (int k = 0; k < NumCorners; k++) begin
            plane_sum = plane_distance(plane_shadow[p], k[0] ? hi[0] : lo[0],
                                       k[1] ? hi[1] : lo[1], k[2] ? hi[2] : lo[2]);
            if (plane_sum <= 0) behind++;
          end
          if (behind == NumCorners) return 1'b0;
        end
        return 1'b1;
      end
      fct_pkg::CMD_POINT: begin
        for (int p = 0; p < NumPlanes; p++) begin
          if (plane_distance(plane_shadow[p], t.min_x, t.min_y, t.min_z) <= 0) return 1'b0;
        end
        return 1'b1;
      end
      fct_pkg::CMD_SPHERE: begin
        reach = longint'(t.radius) <<< OffsetShift;
        // first plane that decides wins, in left..near order
        for (int p = 0; p < NumPlanes; p++) begin
          plane_sum = plane_distance(plane_shadow[p], t.min_x, t.min_y, t.min_z);
          if (plane_sum < -reach) return 1'b0;
          if ((plane_sum < 0 ? -plane_sum : plane_sum) < reach) return 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [PlaneWidth-1:0] plane_word(plane_set_t kind, int p);
    int f [4];
    bit facing_up;
    case (kind)
      PLANES_CUBE, PLANES_BOX: begin
        // inward normals: +x left, -x right, -y top, +y bottom, -z far, +z near
        facing_up = (p == 0 || p == 3 || p == 5);
        for (int k = 0; k < 3; k++) f[k] = 0;
        f[p / 2] = facing_up ? UnitNormal : -UnitNormal;
        f[3] = CubeHalf;
        if (kind == PLANES_BOX) begin
          for (int k = 0; k < 3; k++) f[k] += int'($urandom_range(0, 1024)) - 512;
          f[3] = int'($urandom_range(256, 12288));
        end
        return {16'(f[3]), 16'(f[2]), 16'(f[1]), 16'(f[0])};
      end
      PLANES_RANDOM: return {$urandom, $urandom};
      PLANES_MAXPOS: return 64'h7fff_7fff_7fff_7fff;
      PLANES_MAXNEG: return 64'h8000_8000_8000_8000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return '1;
          2:       return 64'h7fff_7fff_7fff_7fff;
          3:       return 64'h8000_8000_8000_8000;
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [CoordWidth-1:0] near_coord(int span);
    return CoordWidth'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cull_test_t random_test();
    cull_test_t t;
    t.cmd = ($urandom_range(0, 24) == 0) ? fct_pkg::CMD_NONE
                                         : fct_pkg::cmd_t'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      {t.min_x, t.min_y, t.min_z, t.max_x} = {$urandom, $urandom};
      {t.max_y, t.max_z} = $urandom;
      t.radius = RadiusWidth'($urandom);
    end else begin
      t.min_x = near_coord(NearSpan);
      t.min_y = near_coord(NearSpan);
      t.min_z = near_coord(NearSpan);
      if ($urandom_range(0, 4) != 0) begin
        t.max_x = t.min_x + CoordWidth'($urandom_range(0, NearSpan / 2));
        t.max_y = t.min_y + CoordWidth'($urandom_range(0, NearSpan / 2));
        t.max_z = t.min_z + CoordWidth'($urandom_range(0, NearSpan / 2));
      end else begin
        t.max_x = near_coord(NearSpan);
        t.max_y = near_coord(NearSpan);
        t.max_z = near_coord(NearSpan);
      end
      t.radius = RadiusWidth'($urandom_range(0, NearSpan / 2));
    end
    case ($urandom_range(0, 3))
      0, 1: {t.shift_x, t.shift_y, t.shift_z} = '0;
      2: begin
        t.shift_x = near_coord(NearSpan / 4);
        t.shift_y = near_coord(NearSpan / 4);
        t.shift_z = near_coord(NearSpan / 4);
      end
      default: begin
        {t.shift_x, t.shift_y} = $urandom;
        t.shift_z = CoordWidth'($urandom);
      end
    endcase
    return t;
  endfunction

  task automatic queue_directed(fct_pkg::cmd_t c, int mnx, int mny, int mnz, int mxx,
                                int mxy, int mxz, int sx, int sy, int sz, int r);
    cull_test_t t;
    t.cmd     = c;
    t.min_x   = CoordWidth'(mnx);
    t.min_y   = CoordWidth'(mny);
    t.min_z   = CoordWidth'(mnz);
    t.max_x   = CoordWidth'(mxx);
    t.max_y   = CoordWidth'(mxy);
    t.max_z   = CoordWidth'(mxz);
    t.shift_x = CoordWidth'(sx);
    t.shift_y = CoordWidth'(sy);
    t.shift_z = CoordWidth'(sz);
    t.radius  = RadiusWidth'(r);
    pending_tests.push_back(t);
    n_queued++;
  endtask

  task automatic load_planes(plane_set_t kind);
    for (int p = 0; p < NumPlanes; p++) begin
      @(negedge clk);
      wr_en    <= 1'b1;
      wr_index <= CfgIdxWidth'(p);
      wr_data  <= plane_word(kind, p);
    end
    // out-of-range index: must be dropped
    @(negedge clk);
    wr_index <= CfgIdxWidth'($urandom_range(NumPlanes, (1 << CfgIdxWidth) - 1));
    wr_data  <= {$urandom, $urandom};
    @(negedge clk);
    wr_en <= 1'b0;
    n_loads++;
  endtask

  task automatic wait_idle();
    while (n_results < n_queued) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive
    if (start && !xfer) begin
      // hold until the transfer
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_tests.size() != 0) begin
      start    <= 1'b1;
      drv_test <= pending_tests.pop_front();
      gap_left <= $urandom_range(0, gap_limit);
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin : observe
    verdict_t e;
    xfer <= start && !busy;
    if (!rst) begin
      if (wr_en && wr_index < NumPlanes) plane_shadow[wr_index] = wr_data;
      if (start && !busy) begin
        e.t   = drv_test;
        e.vis = cull_verdict(drv_test);
        expected_verdicts.push_back(e);
        cmd_count[drv_test.cmd]++;
        if (!e.vis) n_culled++;
      end
      if (done) begin
        n_results++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with no test outstanding, expected none, actual visible %b",
                   $time, visible);
          n_errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (visible !== e.vis) begin
            $display("%0t: %s at (%0d,%0d,%0d) r=%0d: expected visible %0b, actual %b",
                     $time, e.t.cmd.name(), e.t.min_x, e.t.min_y, e.t.min_z, e.t.radius,
                     e.vis, visible);
            n_errors++;
          end
        end
      end
      if ((start && !busy) || done || wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("** frustum_cull_test: FAILED **");
        $finish;
      end
    end
  end

  initial begin : run
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // planes still at reset: every distance is zero
    queue_directed(fct_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_POINT, 256, -256, 1, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, RadiusMax);
    queue_directed(fct_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    load_planes(PLANES_CUBE);
    @(posedge clk);
    queue_directed(fct_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // on the left plane: zero distance counts as behind
    queue_directed(fct_pkg::CMD_POINT, -CubeHalf, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_POINT, 1 - CubeHalf, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_POINT, CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax, RadiusMax);
    queue_directed(fct_pkg::CMD_POINT, CoordMin, CoordMin, CoordMin, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(fct_pkg::CMD_BOX, CoordMin, CoordMin, CoordMin,
                   CoordMax, CoordMax, CoordMax, 0, 0, 0, RadiusMax);
    queue_directed(fct_pkg::CMD_BOX, CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax, 0, 0, 0, 0);
    // inverted box: corners taken as given
    queue_directed(fct_pkg::CMD_BOX, 2048, 2048, 2048, -2048, -2048, -2048, 0, 0, 0, 0);
    // corner sums need the seventeenth bit
    queue_directed(fct_pkg::CMD_BOX, -256, -256, -256, 256, 256, 256, CoordMax, 0, 0, 0);
    queue_directed(fct_pkg::CMD_BOX, CoordMin, CoordMin, CoordMin,
                   CoordMin, CoordMin, CoordMin,
                   CoordMin, CoordMin, CoordMin, 0);
    queue_directed(fct_pkg::CMD_BOX, CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax,
                   CoordMin, CoordMin, CoordMin, 0);
    queue_directed(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // tangent to the left plane, then one step beyond it
    queue_directed(fct_pkg::CMD_SPHERE, -CubeHalf - 256, 0, 0, 0, 0, 0, 0, 0, 0, 256);
    queue_directed(fct_pkg::CMD_SPHERE, -CubeHalf - 257, 0, 0, 0, 0, 0, 0, 0, 0, 256);
    queue_directed(fct_pkg::CMD_SPHERE, CoordMax, CoordMax, CoordMax,
                   0, 0, 0, 0, 0, 0, RadiusMax);
    queue_directed(fct_pkg::CMD_SPHERE, CoordMin, CoordMin, CoordMin,
                   0, 0, 0, 0, 0, 0, 16);
    queue_directed(fct_pkg::CMD_NONE, CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax,
                   CoordMax, CoordMax, CoordMax, RadiusMax);
    queue_directed(fct_pkg::CMD_NONE, CoordMin, CoordMin, CoordMin,
                   CoordMin, CoordMin, CoordMin,
                   CoordMin, CoordMin, CoordMin, 0);

    for (int s = 0; s < NumSets; s++) begin
      wait_idle();
      load_planes(set_order[s]);
      gap_limit = (s % 3 == 1) ? 0 : 7;
      @(posedge clk);
      repeat (TestsPerSet) begin
        pending_tests.push_back(random_test());
        n_queued++;
      end
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d results missing, expected %0d, actual %0d", $time,
               expected_verdicts.size(), n_queued, n_results);
      n_errors++;
    end
    $display("Checked %0d tests over %0d plane loads: box %0d, point %0d, sphere %0d, none %0d",
             n_queued, n_loads, cmd_count[fct_pkg::CMD_BOX], cmd_count[fct_pkg::CMD_POINT],
             cmd_count[fct_pkg::CMD_SPHERE], cmd_count[fct_pkg::CMD_NONE]);
    $display("Verdicts: %0d culled, %0d visible, %0d mismatches", n_culled,
             n_queued - n_culled, n_errors);
    if (n_errors == 0) begin
      $display("** frustum_cull_test: PASSED **");
    end else begin
      $display("** frustum_cull_test: FAILED **");
    end
    $finish;
  end

endmodule
